@@ rtl/lfu_page_buffer_policy_top_macros.svh @@
// Assertion macros shared by the page buffer RTL.
`ifndef LFU_PAGE_BUFFER_POLICY_TOP_MACROS_SVH
`define LFU_PAGE_BUFFER_POLICY_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LPB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lpb_pkg.sv @@
// Types and constants of the LFU page buffer.
package lpb_pkg;

    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 2;
    localparam int TOTAL_W = 32;

    typedef enum logic {
        OP_ACCESS  = 1'b0,
        OP_INSTALL = 1'b1
    } t_lpb_op;

    typedef struct packed {
        t_lpb_op             command;
        logic [PAGE_W-1:0]   page;
    } t_lpb_in;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                writeback;
        logic [PAGE_W-1:0]   victim_page;
        logic [TOTAL_W-1:0]  hit_total;
        logic [TOTAL_W-1:0]  miss_total;
    } t_lpb_out;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the input beat
        logic commit;   // update slots and load the result register
    } t_lpb_ctl;

endpackage

@@ rtl/lpb_ctrl.sv @@
// Request sequencer of the LFU page buffer.
module lpb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lpb_pkg::t_lpb_ctl o_ctl
);
    import lpb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free     = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_ctl.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_ctl.commit = (r_state == S_EXEC) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/lpb_dpath.sv @@
// Slot store, lookup, LFU victim select and result register.
module lpb_dpath #(
    parameter int WAYS       = 4,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpb_pkg::t_lpb_ctl i_ctl,
    input  lpb_pkg::t_lpb_in  i_in,
    output lpb_pkg::t_lpb_out o_out
);
    import lpb_pkg::*;

    localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LVL   = $clog2(WAYS);
    localparam int NL    = 1 << LVL;

    // request
    t_lpb_op                 r_cmd;
    logic [PAGE_BITS-1:0]    r_page;

    // slot state
    logic [WAYS-1:0]         r_valid;
    logic [PAGE_BITS-1:0]    r_tag   [WAYS];
    logic [COUNT_BITS-1:0]   r_count [WAYS];
    logic [TOTAL_W-1:0]      r_hits;
    logic [TOTAL_W-1:0]      r_misses;
    t_lpb_out                r_out;

    // lookup / placement
    logic [WAYS-1:0]         match;
    logic                    found;
    logic [IDX_W-1:0]        hit_idx;
    logic                    any_empty;
    logic [IDX_W-1:0]        empty_idx;
    logic [IDX_W-1:0]        min_idx;
    logic [IDX_W-1:0]        place;
    logic [IDX_W-1:0]        where;
    logic                    wb;
    logic                    is_miss;
    logic [TOTAL_W-1:0]      n_hits;
    logic [TOTAL_W-1:0]      n_misses;

    // min tree, heap order; leaves at NL..2*NL-1, padding leaves never win
    logic [COUNT_BITS:0]     tr_cnt [1:2*NL-1];
    logic [IDX_W-1:0]        tr_idx [1:2*NL-1];

    always_comb begin
        match     = '0;
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = 0; i < WAYS; i++) begin
            match[i] = r_valid[i] && (r_tag[i] == r_page);
        end
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                empty_idx = IDX_W'(i);
            end
        end
        found     = (r_cmd == OP_ACCESS) && (|match);
        any_empty = !(&r_valid);
    end

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            if (i < WAYS) begin
                tr_cnt[NL+i] = {1'b0, r_count[i]};
                tr_idx[NL+i] = IDX_W'(i);
            end else begin
                tr_cnt[NL+i] = '1;
                tr_idx[NL+i] = '0;
            end
        end
        for (int k = NL - 1; k >= 1; k--) begin
            // strict less: ties keep the left (lower) index
            if (tr_cnt[2*k+1] < tr_cnt[2*k]) begin
                tr_cnt[k] = tr_cnt[2*k+1];
                tr_idx[k] = tr_idx[2*k+1];
            end else begin
                tr_cnt[k] = tr_cnt[2*k];
                tr_idx[k] = tr_idx[2*k];
            end
        end
        min_idx = tr_idx[1];
    end

    assign place    = any_empty ? empty_idx : min_idx;
    assign where    = found ? hit_idx : place;
    assign wb       = !found && !any_empty;
    assign is_miss  = (r_cmd == OP_ACCESS) && !found;
    assign n_hits   = found ? r_hits + 1'b1 : r_hits;
    assign n_misses = is_miss ? r_misses + 1'b1 : r_misses;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_in.command;
            r_page <= PAGE_BITS'(i_in.page);
        end
    end

    // tags hold no reset; they are read only behind a set valid bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && !found) begin
            r_tag[place] <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            for (int i = 0; i < WAYS; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_ctl.commit) begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
            if (found) begin
                if (r_count[hit_idx] != '1) begin
                    r_count[hit_idx] <= r_count[hit_idx] + 1'b1;
                end
            end else begin
                r_valid[place] <= 1'b1;
                r_count[place] <= COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_out.hit         <= found;
            r_out.slot        <= SLOT_W'(where);
            r_out.writeback   <= wb;
            r_out.victim_page <= wb ? PAGE_W'(r_tag[place]) : '0;
            r_out.hit_total   <= n_hits;
            r_out.miss_total  <= n_misses;
        end
    end

    assign o_out = r_out;

endmodule

@@ rtl/lfu_page_buffer_policy_top.sv @@
// Top level of the LFU page buffer replacement policy.
// A WAYS-slot page buffer with least-frequently-used replacement. Each input beat
// carries a command and a page number. An access looks the page up in all slots;
// a hit bumps that slot's saturating use count and the hit total, a miss bumps the
// miss total and installs the page. An install places the page without a lookup,
// so a page may end up in more than one slot (a lookup then hits the lowest one).
// Placement takes the lowest empty slot, else the lowest use count with ties to the
// lower index; a replaced valid page comes back with writeback set and its number
// in victim_page. Each input beat gives exactly one output beat. A new beat is not
// taken until the last is done: the idle state captures the request, the exec state
// does the tag compare, victim select and slot update and loads the output register.
// The update waits while that register holds a result not yet taken, so a stalled
// output side holds the block after one further request. Slot storage is
// flip-flops; no clearing pass follows reset.
module lfu_page_buffer_policy_top #(
    parameter int WAYS       = 4,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lpb_pkg::t_lpb_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lpb_pkg::t_lpb_out o_out
);
    import lpb_pkg::*;

    `include "lfu_page_buffer_policy_top_macros.svh"

    t_lpb_ctl w_ctl;

    // control: handshakes and sequencing
    lpb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (w_ctl)
    );

    // datapath: slots, counters, result register
    lpb_dpath #(
        .WAYS       (WAYS),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // An accepted beat keeps the block busy for the next cycle.
    `LPB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input accepted while request in flight")
    // The result register is only overwritten once its beat is gone.
    `LPB_ASSERT_NOW(a_commit_free, i_clk, i_rst_n, w_ctl.commit, !o_out_valid || i_out_ready, "result overwritten before taken")
    // A taken result with no new commit leaves the output empty.
    `LPB_ASSERT_NEXT(a_out_drain, i_clk, i_rst_n, o_out_valid && i_out_ready && !w_ctl.commit, !o_out_valid, "output beat repeated")
    // A hit never replaces a page.
    `LPB_ASSERT_NOW(a_hit_no_wb, i_clk, i_rst_n, o_out_valid, !(o_out.hit && o_out.writeback), "hit reported with writeback")

endmodule
